// ===== src/fmo_pkg.sv =====
// Shared constants, status codes and types for the FIFO mutex with owner check.
package fmo_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    localparam int FIELD_W = 8;
    localparam int IDW     = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_HANDOFF = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    typedef struct packed {
        logic [IDW-1:0] net;
        logic [IDW-1:0] mbx;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t data;
    } chain_ctrl_t;

endpackage

// ===== src/fmo_cell.sv =====
// One waiter cell: holds a single queue entry and takes its neighbor's entry on a pop.
module fmo_cell (
    input  logic               clk,
    input  fmo_pkg::chain_ctrl_t ctrl,
    input  logic               sel,
    input  fmo_pkg::entry_t    shift_in,
    output fmo_pkg::entry_t    data
);

    fmo_pkg::entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            data_reg <= shift_in;
        end
        else if (ctrl.push && sel)
        begin
            data_reg <= ctrl.data;
        end
    end

    assign data = data_reg;

endmodule

// ===== src/fmo_waiter_chain.sv =====
// Row of waiter cells forming a shifting first-in first-out queue with the oldest waiter at cell 0.
module fmo_waiter_chain (
    input  logic                      clk,
    input  fmo_pkg::chain_ctrl_t      ctrl,
    input  logic [fmo_pkg::IDX_W-1:0] push_idx,
    output fmo_pkg::entry_t           head
);

    fmo_pkg::entry_t link [0:fmo_pkg::QUEUE_DEPTH];

    assign link[fmo_pkg::QUEUE_DEPTH] = '0;

    genvar i;
    generate
        for (i = 0; i < fmo_pkg::QUEUE_DEPTH; i++)
        begin : g_cell
            fmo_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .sel      (push_idx == fmo_pkg::IDX_W'(i)),
                .shift_in (link[i+1]),
                .data     (link[i])
            );
        end
    endgenerate

    assign head = link[0];

endmodule

// ===== src/fifo_mutex_with_owner_check.sv =====
// Top level of the FIFO mutex: owner registers, waiter count, cell chain and result register.
// The block takes one transaction per clock cycle while its result register is empty or being
// taken, and returns the result in the cycle after acceptance, held in an output register until
// taken; a new request is accepted while the result is being taken in the same cycle. Each
// request updates the owner registers and one end of the waiter chain only. Waiters sit in a row
// of cells with the oldest at the front; a handoff shifts the whole row by one. No clearing pass
// is needed after reset.
module fifo_mutex_with_owner_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] requester_network,
    input  logic [7:0] requester_mailbox,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic       owner_valid,
    output logic [7:0] new_owner_network,
    output logic [7:0] new_owner_mailbox,
    output logic       lock_busy
);

    logic                      busy_reg, busy_next;
    fmo_pkg::entry_t           owner_reg, owner_next;
    logic [fmo_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      out_valid_reg;
    logic [2:0]                status_reg, status_next;
    logic                      owner_valid_reg, owner_valid_next;
    fmo_pkg::entry_t           res_owner_reg, res_owner_next;

    fmo_pkg::entry_t           req;
    fmo_pkg::entry_t           head;
    fmo_pkg::chain_ctrl_t      ctrl;
    logic                      accept;
    logic                      full;
    logic                      empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign req.net  = requester_network[fmo_pkg::IDW-1:0];
    assign req.mbx  = requester_mailbox[fmo_pkg::IDW-1:0];
    assign full     = (count_reg == fmo_pkg::CNT_W'(fmo_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        busy_next        = busy_reg;
        owner_next       = owner_reg;
        count_next       = count_reg;
        status_next      = fmo_pkg::ST_INVALID;
        owner_valid_next = 1'b0;
        res_owner_next   = '0;
        ctrl.push        = 1'b0;
        ctrl.pop         = 1'b0;
        ctrl.data        = req;
        if (mode == fmo_pkg::MODE_ACQUIRE)
        begin
            if (!busy_reg)
            begin
                busy_next        = 1'b1;
                owner_next       = req;
                status_next      = fmo_pkg::ST_GRANTED;
                owner_valid_next = 1'b1;
                res_owner_next   = req;
            end
            else if (full)
            begin
                status_next = fmo_pkg::ST_FULL;
            end
            else
            begin
                ctrl.push   = accept;
                count_next  = count_reg + 1'b1;
                status_next = fmo_pkg::ST_QUEUED;
            end
        end
        else if (req == owner_reg)
        begin
            if (empty)
            begin
                busy_next   = 1'b0;
                status_next = fmo_pkg::ST_FREED;
            end
            else
            begin
                ctrl.pop         = accept;
                owner_next       = head;
                count_next       = count_reg - 1'b1;
                busy_next        = 1'b1;
                status_next      = fmo_pkg::ST_HANDOFF;
                owner_valid_next = 1'b1;
                res_owner_next   = head;
            end
        end
    end

    fmo_waiter_chain u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .push_idx (count_reg[fmo_pkg::IDX_W-1:0]),
        .head     (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg  <= busy_next;
                owner_reg <= owner_next;
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            owner_valid_reg <= owner_valid_next;
            res_owner_reg   <= res_owner_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign owner_valid       = owner_valid_reg;
    assign new_owner_network = fmo_pkg::FIELD_W'(res_owner_reg.net);
    assign new_owner_mailbox = fmo_pkg::FIELD_W'(res_owner_reg.mbx);
    assign lock_busy         = busy_reg;

endmodule

// ===== src/fmo_checker.sv =====
// Port-level checker for the FIFO mutex and its bind to the top level.
module fmo_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       mode,
    input logic [7:0] requester_network,
    input logic [7:0] requester_mailbox,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       owner_valid,
    input logic [7:0] new_owner_network,
    input logic [7:0] new_owner_mailbox,
    input logic       lock_busy
);

    // A stalled result must stay on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(new_owner_network))
        else $error("result changed while stalled");

    // Every accepted request yields a result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    a_owner_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owner_valid == (status == fmo_pkg::ST_GRANTED
                                      || status == fmo_pkg::ST_HANDOFF))
        else $error("owner_valid does not match status");

    a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !owner_valid |-> new_owner_network == 8'd0 && new_owner_mailbox == 8'd0)
        else $error("owner fields not zero without an owner");

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fmo_pkg::ST_GRANTED || status == fmo_pkg::ST_HANDOFF
                      || status == fmo_pkg::ST_QUEUED || status == fmo_pkg::ST_FULL)
        |-> lock_busy)
        else $error("lock reported free after a busy outcome");

endmodule

bind fifo_mutex_with_owner_check fmo_checker u_fmo_checker (.*);

// ===== verif/fifo_mutex_with_owner_check_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the FIFO mutex with owner check: directed and random requests.
module fifo_mutex_with_owner_check_tb;

    typedef struct {
        logic       mode;
        logic [7:0] net;
        logic [7:0] mbx;
        int         gap;
    } lock_request_t;

    typedef struct packed {
        logic [2:0] status;
        logic       owner_valid;
        logic [7:0] net;
        logic [7:0] mbx;
        logic       busy;
    } lock_outcome_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       mode = fmo_pkg::MODE_ACQUIRE;
    logic [7:0] requester_network = 8'h00;
    logic [7:0] requester_mailbox = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic       owner_valid;
    logic [7:0] new_owner_network;
    logic [7:0] new_owner_mailbox;
    logic       lock_busy;

    lock_request_t request_queue[$];
    lock_request_t drive_item;
    lock_outcome_t pending_outcomes[$];
    lock_outcome_t wanted_outcome;
    lock_outcome_t seen_outcome;
    int            mismatch_count = 0;
    int            gap_count = 0;
    int            stall_left = 0;
    int            stall_next = 0;
    int            results_taken = 0;

    logic            lock_held = 1'b0;
    fmo_pkg::entry_t lock_owner = '0;
    fmo_pkg::entry_t lock_waiters[$];

    fmo_pkg::entry_t stim_holders[$];
    fmo_pkg::entry_t stim_last_owner = '0;

    fifo_mutex_with_owner_check i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .requester_network (requester_network),
        .requester_mailbox (requester_mailbox),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .owner_valid       (owner_valid),
        .new_owner_network (new_owner_network),
        .new_owner_mailbox (new_owner_mailbox),
        .lock_busy         (lock_busy)
    );

    always #2 clk = ~clk;

    function automatic int draw_wait(input bit quiet);
        if (quiet)
        begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void predict_lock_outcome(input logic req_mode, input logic [7:0] net,
                                                 input logic [7:0] mbx);
        fmo_pkg::entry_t who;
        lock_outcome_t   res;
        who.net = net;
        who.mbx = mbx;
        res = '0;
        if (req_mode == fmo_pkg::MODE_ACQUIRE)
        begin
            if (!lock_held)
            begin
                lock_held = 1'b1;
                lock_owner = who;
                res.status = fmo_pkg::ST_GRANTED;
                res.owner_valid = 1'b1;
            end
            else if (lock_waiters.size() >= fmo_pkg::QUEUE_DEPTH)
            begin
                res.status = fmo_pkg::ST_FULL;
            end
            else
            begin
                lock_waiters.push_back(who);
                res.status = fmo_pkg::ST_QUEUED;
            end
        end
        else if (who == lock_owner)
        begin
            if (lock_waiters.size() == 0)
            begin
                lock_held = 1'b0;
                res.status = fmo_pkg::ST_FREED;
            end
            else
            begin
                lock_owner = lock_waiters.pop_front();
                res.status = fmo_pkg::ST_HANDOFF;
                res.owner_valid = 1'b1;
            end
        end
        else
        begin
            res.status = fmo_pkg::ST_INVALID;
        end
        if (res.owner_valid)
        begin
            res.net = lock_owner.net;
            res.mbx = lock_owner.mbx;
        end
        res.busy = lock_held;
        pending_outcomes.push_back(res);
    endfunction

    function automatic void queue_request(input logic req_mode, input fmo_pkg::entry_t who,
                                          input bit quiet);
        lock_request_t r;
        r.mode = req_mode;
        r.net = who.net;
        r.mbx = who.mbx;
        r.gap = draw_wait(quiet);
        request_queue.push_back(r);
        if (req_mode == fmo_pkg::MODE_ACQUIRE)
        begin
            if (stim_holders.size() <= fmo_pkg::QUEUE_DEPTH)
            begin
                stim_holders.push_back(who);
            end
        end
        else if (stim_holders.size() > 0 && who == stim_holders[0])
        begin
            stim_last_owner = stim_holders.pop_front();
        end
    endfunction

    function automatic fmo_pkg::entry_t current_owner();
        if (stim_holders.size() > 0)
        begin
            return stim_holders[0];
        end
        return stim_last_owner;
    endfunction

    function automatic fmo_pkg::entry_t pick_client();
        fmo_pkg::entry_t who;
        int              idx;
        idx = $urandom_range(0, 5);
        if ($urandom_range(0, 1) == 0)
        begin
            who.net = 8'h10 + 8'(idx);
            who.mbx = 8'hA0 + 8'(idx);
        end
        else
        begin
            who.net = 8'($urandom_range(0, 255));
            who.mbx = 8'($urandom_range(0, 255));
        end
        return who;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_lock_outcome(mode, requester_network, requester_mailbox);
            end
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_count < request_queue[0].gap)
                begin
                    in_valid <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else
                begin
                    drive_item = request_queue.pop_front();
                    in_valid <= 1'b1;
                    mode <= drive_item.mode;
                    requester_network <= drive_item.net;
                    requester_mailbox <= drive_item.mbx;
                    gap_count <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            seen_outcome = {status, owner_valid, new_owner_network, new_owner_mailbox, lock_busy};
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Unexpected transaction: status=%0d owner_valid=%0b net=%02h",
                             status, owner_valid, new_owner_network);
                    $display("    mbx=%02h busy=%0b", new_owner_mailbox, lock_busy);
                end
            end
            else
            begin
                wanted_outcome = pending_outcomes.pop_front();
                if (seen_outcome !== wanted_outcome)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch at transaction %0d:", results_taken);
                        $display("    expected status=%0d owner_valid=%0b net=%02h mbx=%02h busy=%0b",
                                 wanted_outcome.status, wanted_outcome.owner_valid,
                                 wanted_outcome.net, wanted_outcome.mbx, wanted_outcome.busy);
                        $display("    got      status=%0d owner_valid=%0b net=%02h mbx=%02h busy=%0b",
                                 seen_outcome.status, seen_outcome.owner_valid,
                                 seen_outcome.net, seen_outcome.mbx, seen_outcome.busy);
                    end
                end
            end
            results_taken <= results_taken + 1;
            stall_next = draw_wait(((results_taken / 40) % 3) == 0);
            stall_left <= stall_next;
            out_ready <= (stall_next == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int phase;
        int acquire_share;
        int pick;
        bit quiet;

        // A release of the untouched lock by ids 0/0 matches the reset owner and frees it again.
        queue_request(fmo_pkg::MODE_RELEASE, '{8'h00, 8'h00}, 1'b0);
        queue_request(fmo_pkg::MODE_RELEASE, '{8'hFF, 8'hFF}, 1'b0);
        queue_request(fmo_pkg::MODE_ACQUIRE, '{8'h80, 8'h01}, 1'b0);
        // The owner asking again is queued behind itself.
        queue_request(fmo_pkg::MODE_ACQUIRE, '{8'h80, 8'h01}, 1'b0);
        for (int i = 0; i < 15; i++)
        begin
            queue_request(fmo_pkg::MODE_ACQUIRE, '{8'(i * 17), 8'(~(i * 17))}, 1'b0);
        end
        queue_request(fmo_pkg::MODE_ACQUIRE, '{8'h7F, 8'hFE}, 1'b0);
        queue_request(fmo_pkg::MODE_RELEASE, '{8'h01, 8'h80}, 1'b0);
        queue_request(fmo_pkg::MODE_RELEASE, '{8'h80, 8'h01}, 1'b0);
        queue_request(fmo_pkg::MODE_RELEASE, '{8'h80, 8'h01}, 1'b0);

        for (int blk = 0; blk < 20; blk++)
        begin
            phase = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            acquire_share = (phase == 1) ? 85 : ((phase == 2) ? 10 : 45);
            for (int k = 0; k < 50; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < acquire_share)
                begin
                    queue_request(fmo_pkg::MODE_ACQUIRE, pick_client(), quiet);
                end
                else if (pick < 90)
                begin
                    queue_request(fmo_pkg::MODE_RELEASE, current_owner(), quiet);
                end
                else
                begin
                    queue_request(fmo_pkg::MODE_RELEASE, pick_client(), quiet);
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid || pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fmo_pkg.sv
src/fmo_cell.sv
src/fmo_waiter_chain.sv
src/fifo_mutex_with_owner_check.sv
src/fmo_checker.sv
verif/fifo_mutex_with_owner_check_tb.sv
